FILE: rtl/core/abar_pkg.sv
// Shared types, register codes and scaling helpers for the antialiased bar column.
package abar_pkg;

	localparam int unsigned ROWS = 8;
	localparam int unsigned ROW_W = 3;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned PROD_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned QDEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;

	localparam logic [LEVEL_W-1:0] GREEN_BG = 8'd7;
	localparam logic [4:0] FRAC_MASK = 5'h1F;

	// One classified bar word: whole rows, sign and the fraction times brightness, not yet divided by 255.
	typedef struct packed {
		logic [ROW_W-1:0] whole;
		logic negative;
		logic [PROD_W-1:0] part_prod;
	} item_t;

	// floor(p / 255) for p up to 255*255, by add and shift.
	function automatic logic [LEVEL_W-1:0] div255(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] s;
		s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
		return s[15:8];
	endfunction

endpackage

FILE: rtl/core/abar_front.sv
// Front end: accept a bar word, split it into whole rows and fraction, scale the fraction.
module abar_front (
	input  logic                                start,
	input  logic                                full,
	input  logic [7:0]                          bar_value,
	input  logic                                negative,
	input  logic [abar_pkg::LEVEL_W-1:0]        brightness,
	output logic                                push,
	output abar_pkg::item_t                     item
);

	logic [abar_pkg::LEVEL_W-1:0] frac;

	assign push = start && !full;
	// Fraction bits moved to the top of an 8-bit level.
	assign frac = {bar_value[4:0] & abar_pkg::FRAC_MASK, 3'b000};

	always_comb begin
		item.whole = bar_value[7:5];
		item.negative = negative;
		item.part_prod = {8'd0, frac} * {8'd0, brightness};
	end

endmodule

FILE: rtl/core/abar_queue.sv
// Short queue of classified bar words between the front and back ends.
module abar_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  abar_pkg::item_t wr_item,
	input  logic            pop,
	output abar_pkg::item_t head,
	output logic            empty,
	output logic            full
);

	abar_pkg::item_t mem [abar_pkg::QDEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'(abar_pkg::QDEPTH));
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/core/abar_back.sv
// Back end: walk the eight rows of the head word and register one pixel per cycle while a word is queued.
module abar_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  abar_pkg::item_t                 head,
	input  logic                            empty,
	input  logic [2:0]                      column,
	input  logic [abar_pkg::LEVEL_W-1:0]    brightness,
	output logic                            pop,
	output logic                            strobe,
	output logic [5:0]                      pixel_index,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic                            last
);

	logic [abar_pkg::ROW_W-1:0] row_q;
	logic [abar_pkg::LEVEL_W-1:0] level;
	logic [abar_pkg::LEVEL_W-1:0] bg;
	logic [abar_pkg::PROD_W-1:0] bg_prod;
	logic is_last;

	assign is_last = (row_q == 3'(abar_pkg::ROWS - 1));
	assign pop = !empty && is_last;
	assign bg_prod = {8'd0, abar_pkg::GREEN_BG} * {8'd0, brightness};
	assign bg = abar_pkg::div255(bg_prod);

	always_comb begin
		// Full rows scale 255 by brightness, which is brightness itself.
		if (row_q < head.whole) begin
			level = brightness;
		end else if (row_q == head.whole) begin
			level = abar_pkg::div255(head.part_prod);
		end else begin
			level = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= !empty;
			if (!empty) begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			pixel_index <= {column, row_q};
			red <= head.negative ? level : 8'd0;
			green <= bg;
			blue <= head.negative ? 8'd0 : level;
			last <= is_last;
		end
	end

endmodule

FILE: rtl/core/antialiased_bar_column_top.sv
// Top level of the antialiased bar column: config registers, front, queue and back.
//
// Usage: pulse start with bar_value and negative; the word is taken at a rising
// edge where start is high and busy is low. Each word yields eight pixel words,
// rows 0 to 7 of the configured column, back to back, each marked by strobe for
// one cycle; last is high on row 7. A word is first written into the queue; the
// back end registers its first pixel once it is the queue head. The back end
// emits one row per cycle while a word is queued. A two-entry queue lets the next
// word be taken while the current one is still being emitted, so words sent as
// fast as the back end takes them stream without gaps; busy is high only while
// the queue is full.
// Configuration: cfg_we with cfg_index 0 writes column (low 3 bits), index 1
// writes brightness (low 8 bits); other indexes are dropped. Write only while idle.
// Reset (arst_n low) empties the queue, clears strobe, sets column 0 and
// brightness 255. The receiver cannot stall: pixel words are never held.
module antialiased_bar_column_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [7:0]                          bar_value,
	input  logic                                negative,
	input  logic                                cfg_we,
	input  logic [abar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                          cfg_data,
	output logic                                strobe,
	output logic [5:0]                          pixel_index,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                last
);

	logic [2:0] column_q;
	logic [abar_pkg::LEVEL_W-1:0] brightness_q;
	logic push;
	logic pop;
	logic empty;
	logic full;
	abar_pkg::item_t wr_item;
	abar_pkg::item_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 3'd0;
			brightness_q <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				abar_pkg::REG_COLUMN: column_q <= cfg_data[2:0];
				abar_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = full;

	abar_front u_front (
		.start(start),
		.full(full),
		.bar_value(bar_value),
		.negative(negative),
		.brightness(brightness_q),
		.push(push),
		.item(wr_item)
	);

	abar_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(wr_item),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	abar_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.column(column_q),
		.brightness(brightness_q),
		.pop(pop),
		.strobe(strobe),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.last(last)
	);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the antialiased bar column: directed and random bar words.
module tb_top;

	localparam logic [abar_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [abar_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int BARS_PER_PHASE = 70;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [7:0] bar_value;
	logic negative;
	logic cfg_we;
	logic [abar_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic strobe;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic last;

	typedef struct packed {
		logic [5:0] index;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic lst;
	} pixel_t;

	pixel_t pending_pixels[$];
	logic [2:0] col_shadow;
	logic [7:0] bright_shadow;
	int bars_sent;
	int pixels_checked;
	int mismatches;
	int quiet_cycles;

	antialiased_bar_column_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.bar_value(bar_value),
		.negative(negative),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] scale_level(input logic [7:0] level,
		input logic [7:0] bright);
		logic [15:0] prod;
		prod = 16'(level) * 16'(bright);
		return 8'(prod / 16'd255);
	endfunction

	// Queue the eight pixels of one bar word under the current register values.
	task automatic predict_column_pixels(input logic [7:0] v, input logic n);
		logic [2:0] whole;
		logic [7:0] full_lvl;
		logic [7:0] part_lvl;
		logic [7:0] bg;
		logic [7:0] lvl;
		pixel_t px;
		whole = v[7:5];
		full_lvl = scale_level(8'd255, bright_shadow);
		part_lvl = scale_level({v[4:0], 3'b000}, bright_shadow);
		bg = scale_level(abar_pkg::GREEN_BG, bright_shadow);
		for (int row = 0; row < abar_pkg::ROWS; row++) begin
			if (row < whole) begin
				lvl = full_lvl;
			end else if (row == whole) begin
				lvl = part_lvl;
			end else begin
				lvl = 8'd0;
			end
			px.index = {col_shadow, 3'(row)};
			px.r = n ? lvl : 8'd0;
			px.g = bg;
			px.b = n ? 8'd0 : lvl;
			px.lst = (row == abar_pkg::ROWS - 1);
			pending_pixels.push_back(px);
		end
	endtask

	// Entered and left at a falling edge; start stays high on return.
	task automatic send_bar(input logic [7:0] v, input logic n);
		start = 1'b1;
		bar_value = v;
		negative = n;
		do @(posedge clk); while (busy);
		predict_column_pixels(v, n);
		bars_sent++;
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start = 1'b0;
			bar_value = 8'($urandom_range(0, 255));
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every queued pixel has come out.
	task automatic drain_pixels();
		start = 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [abar_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] d);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			abar_pkg::REG_COLUMN: col_shadow = d[2:0];
			abar_pkg::REG_BRIGHTNESS: bright_shadow = d;
			default: ;
		endcase
	endtask

	function automatic logic [7:0] random_bar();
		case ($urandom_range(0, 7))
			0: return {3'($urandom_range(0, 7)), 5'd0};
			1: return {3'd7, 5'($urandom_range(0, 31))};
			2: return {3'($urandom_range(0, 7)), abar_pkg::FRAC_MASK};
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Every strobe must match the oldest queued pixel.
	always @(posedge clk) begin : check_pixels
		pixel_t want;
		pixel_t got;
		if (arst_n && strobe) begin
			got = {pixel_index, red, green, blue, last};
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected pixel idx=%0d r=%0d g=%0d b=%0d last=%0b",
						$realtime, got.index, got.r, got.g, got.b, got.lst);
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (got.index !== want.index || got.r !== want.r || got.g !== want.g ||
					got.b !== want.b || got.lst !== want.lst) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: pixel mismatch exp idx=%0d r=%0d g=%0d b=%0d last=%0b,",
							$realtime, want.index, want.r, want.g, want.b, want.lst);
						$display(" got idx=%0d r=%0d g=%0d b=%0d last=%0b",
							got.index, got.r, got.g, got.b, got.lst);
					end
				end
			end
		end
	end

	// Abort when neither side moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("watchdog: no progress for %0d cycles, %0d pixels outstanding",
						quiet_cycles, pending_pixels.size());
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	task automatic test_reset_defaults();
		send_bar(8'hFF, 1'b1);
		send_bar(8'h00, 1'b0);
		drain_pixels();
	endtask

	task automatic test_directed_bars();
		logic [7:0] vals[10];
		vals = '{8'h00, 8'hFF, 8'h1F, 8'h20, 8'h3F, 8'hE0, 8'hDF, 8'h80, 8'h01, 8'hA5};
		foreach (vals[k]) begin
			send_bar(vals[k], 1'b0);
			send_bar(vals[k], 1'b1);
			if (k % 3 == 0)
				hold_off($urandom_range(1, 9));
		end
		drain_pixels();
	endtask

	// Wide data, spare indexes and brightness extremes.
	task automatic test_register_writes();
		write_reg(abar_pkg::REG_COLUMN, 8'hFF);
		write_reg(abar_pkg::REG_BRIGHTNESS, 8'h00);
		send_bar(8'hFF, 1'b1);
		drain_pixels();
		write_reg(REG_SPARE2, 8'h55);
		write_reg(REG_SPARE3, 8'hAA);
		send_bar(8'h9C, 1'b0);
		drain_pixels();
		write_reg(abar_pkg::REG_COLUMN, 8'hFA);
		write_reg(abar_pkg::REG_BRIGHTNESS, 8'h01);
		send_bar(8'hFF, 1'b0);
		drain_pixels();
		write_reg(abar_pkg::REG_BRIGHTNESS, 8'hFE);
		send_bar(8'h7B, 1'b1);
		drain_pixels();
	endtask

	task automatic test_random_phases();
		int left;
		int burst;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_pixels();
			case (ph)
				0: begin
					write_reg(abar_pkg::REG_COLUMN, 8'h00);
					write_reg(abar_pkg::REG_BRIGHTNESS, 8'hFF);
				end
				1: begin
					write_reg(abar_pkg::REG_COLUMN, 8'h07);
					write_reg(abar_pkg::REG_BRIGHTNESS, 8'h00);
				end
				default: begin
					write_reg(abar_pkg::REG_COLUMN, 8'($urandom_range(0, 255)));
					write_reg(abar_pkg::REG_BRIGHTNESS, 8'($urandom_range(0, 255)));
				end
			endcase
			if ($urandom_range(0, 1))
				write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
					8'($urandom_range(0, 255)));
			left = BARS_PER_PHASE;
			while (left > 0) begin
				burst = $urandom_range(1, 16);
				if (burst > left)
					burst = left;
				repeat (burst) send_bar(random_bar(), 1'($urandom_range(0, 1)));
				left -= burst;
				// Phase 2 streams without gaps; phase 3 drains once midway.
				if (ph == 3 && left < BARS_PER_PHASE / 2 && left + burst >= BARS_PER_PHASE / 2)
					drain_pixels();
				else if (ph != 2 && $urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 12));
			end
		end
		drain_pixels();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		bar_value = 8'd0;
		negative = 1'b0;
		cfg_we = 1'b0;
		cfg_index = abar_pkg::REG_COLUMN;
		cfg_data = 8'd0;
		col_shadow = 3'd0;
		bright_shadow = 8'd255;
		bars_sent = 0;
		pixels_checked = 0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed_bars();
		test_register_writes();
		test_random_phases();

		drain_pixels();
		repeat (10) @(posedge clk);
		$display("Sent %0d bar words and checked %0d pixels across columns and brightness levels.",
			bars_sent, pixels_checked);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
